### rtl/spreadsheet_cell_notation_converter_macros.svh
// assertion macros shared by the converter modules
`ifndef SPREADSHEET_CELL_NOTATION_CONVERTER_MACROS_SVH
`define SPREADSHEET_CELL_NOTATION_CONVERTER_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/scc_pkg.sv
// types, constants and helpers for the cell notation converter
package scc_pkg;

	localparam int VALUE_BITS  = 20;
	localparam int BURST_MAX   = 16;
	localparam int BUF_DEPTH   = 32;
	localparam int BUF_AW      = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int POS_W       = 5;
	localparam int PROD_W      = VALUE_BITS + 32;
	localparam int RECIP_SHIFT = 35;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_C = 8'h43;

	localparam logic [VALUE_BITS-1:0] LETTER_R = VALUE_BITS'(18);
	localparam logic [4:0]            RADIX_10 = 5'd10;
	localparam logic [4:0]            RADIX_26 = 5'd26;

	// floor(x/10) = (x * RECIP_10) >> 35, floor(x/26) = (x * RECIP_26) >> 35, x < 2^32
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam logic [31:0] RECIP_26 = 32'h4EC4_EC4F;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       error;
	} out_req_t;

	typedef struct packed {
		logic                  bad;
		logic                  rc_form;
		logic [VALUE_BITS-1:0] row;
		logic [VALUE_BITS-1:0] col;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEG,
		B_MUL,
		B_DIG,
		B_RD,
		B_PUT,
		B_ERR
	} back_state_t;

	typedef enum logic [2:0] {
		SEG_DEC,
		SEG_LET,
		SEG_CHR_C,
		SEG_CHR_R,
		SEG_END
	} seg_kind_t;

endpackage

### rtl/scc_front.sv
// front end character classifier: letter and digit detection with their codes
module scc_front (
	input  logic [7:0] in_char,
	output logic       is_letter,
	output logic       is_digit,
	output logic [4:0] letter_code,
	output logic [4:0] digit_code
);
	import scc_pkg::*;

	assign is_letter   = (in_char >= CH_A) && (in_char <= CH_Z);
	assign is_digit    = (in_char >= CH_0) && (in_char <= CH_9);
	assign letter_code = 5'(in_char - CH_A) + 5'd1;
	assign digit_code  = 5'(in_char - CH_0);

endmodule

### rtl/scc_queue.sv
// two-entry token queue between front and back end
`include "spreadsheet_cell_notation_converter_macros.svh"

module scc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  scc_pkg::q_ctl_t q_ctl,
	input  scc_pkg::job_t   push_job,
	input  logic            pop,
	output logic            q_valid,
	output scc_pkg::job_t   q_job,
	output logic            full
);
	import scc_pkg::*;

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign q_valid = (count_q != '0);
	assign full    = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_job   = entry_q[rd_ptr_q];
	assign do_push = q_ctl.push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	`SCC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count above depth")
	`SCC_ASSERT_NOW(a_no_push_full, clk, arst_n, q_ctl.push, !q_ctl.full && !full, "token pushed into full queue")

endmodule

### rtl/scc_back.sv
// back end: converts a token into text in the emit buffer and streams it out
`include "spreadsheet_cell_notation_converter_macros.svh"

module scc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  scc_pkg::job_t     q_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output scc_pkg::out_req_t out_req
);
	import scc_pkg::*;

	localparam logic [BUF_AW-1:0] BUF_TOP  = BUF_AW'(BUF_DEPTH - 1);
	localparam logic [BUF_AW-1:0] OVER_PTR = BUF_AW'(BUF_DEPTH - 1 - BURST_MAX);

	back_state_t           state_q, state_d;
	job_t                  job_q;
	logic [2:0]            seg_q, seg_d;
	logic [BUF_AW-1:0]     ptr_q, ptr_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic                  let_q, let_d;
	logic [VALUE_BITS-1:0] opnd_s1, opnd_d;
	logic [PROD_W-1:0]     prod_s1;
	logic [7:0]            rd_char_q;
	logic                  out_valid_q;
	out_req_t              out_q, out_d;

	logic                  out_free;
	logic                  out_load;
	logic                  wr_en;
	logic                  rd_en;
	logic [7:0]            wr_char;
	logic                  job_load;
	seg_kind_t             kind;
	logic [VALUE_BITS-1:0] seg_val;
	logic [VALUE_BITS-1:0] quo;
	logic [VALUE_BITS-1:0] rem;
	logic [7:0]            emit_buf [BUF_DEPTH];

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_req   = out_q;

	always_comb begin
		kind    = SEG_END;
		seg_val = job_q.row;
		if (job_q.rc_form) begin
			unique case (seg_q)
				3'd0: begin
					kind    = SEG_DEC;
					seg_val = job_q.row;
				end
				3'd1: begin
					kind    = SEG_LET;
					seg_val = job_q.col;
				end
				default: kind = SEG_END;
			endcase
		end else begin
			unique case (seg_q)
				3'd0: begin
					kind    = SEG_DEC;
					seg_val = job_q.col;
				end
				3'd1:    kind = SEG_CHR_C;
				3'd2: begin
					kind    = SEG_DEC;
					seg_val = job_q.row;
				end
				3'd3:    kind = SEG_CHR_R;
				default: kind = SEG_END;
			endcase
		end
	end

	assign quo = VALUE_BITS'(prod_s1 >> RECIP_SHIFT);
	assign rem = opnd_s1 - quo * (let_q ? VALUE_BITS'(RADIX_26) : VALUE_BITS'(RADIX_10));

	always_comb begin
		state_d  = state_q;
		seg_d    = seg_q;
		ptr_d    = ptr_q;
		val_d    = val_q;
		let_d    = let_q;
		opnd_d   = let_q ? val_q - 1'b1 : val_q;
		pop      = 1'b0;
		job_load = 1'b0;
		wr_en    = 1'b0;
		wr_char  = CH_0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		out_d    = '{out_char: rd_char_q, out_last: (ptr_q == BUF_TOP), error: 1'b0};
		unique case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					pop      = 1'b1;
					job_load = 1'b1;
					seg_d    = '0;
					ptr_d    = BUF_TOP;
					state_d  = q_job.bad ? B_ERR : B_SEG;
				end
			end
			B_SEG: begin
				unique case (kind)
					SEG_DEC, SEG_LET: begin
						val_d   = seg_val;
						let_d   = (kind == SEG_LET);
						state_d = B_MUL;
					end
					SEG_CHR_C, SEG_CHR_R: begin
						wr_en   = 1'b1;
						wr_char = (kind == SEG_CHR_C) ? CH_C : CH_R;
						ptr_d   = ptr_q - 1'b1;
						seg_d   = seg_q + 1'b1;
					end
					default: begin
						if (ptr_q < OVER_PTR) begin
							state_d = B_ERR;
						end else begin
							ptr_d   = ptr_q + 1'b1;
							state_d = B_RD;
						end
					end
				endcase
			end
			B_MUL: begin
				state_d = B_DIG;
			end
			B_DIG: begin
				wr_en   = 1'b1;
				wr_char = (let_q ? CH_A : CH_0) + {3'b000, rem[4:0]};
				ptr_d   = ptr_q - 1'b1;
				val_d   = quo;
				if (quo == '0) begin
					seg_d   = seg_q + 1'b1;
					state_d = B_SEG;
				end else begin
					state_d = B_MUL;
				end
			end
			B_RD: begin
				rd_en   = 1'b1;
				state_d = B_PUT;
			end
			B_PUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (ptr_q == BUF_TOP) begin
						state_d = B_IDLE;
					end else begin
						ptr_d   = ptr_q + 1'b1;
						state_d = B_RD;
					end
				end
			end
			B_ERR: begin
				out_d = '{out_char: 8'h00, out_last: 1'b1, error: 1'b1};
				if (out_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			seg_q       <= '0;
			ptr_q       <= '0;
			let_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seg_q   <= seg_d;
			ptr_q   <= ptr_d;
			let_q   <= let_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
		if (job_load) begin
			job_q <= q_job;
		end
		if (state_q == B_MUL) begin
			opnd_s1 <= opnd_d;
			prod_s1 <= PROD_W'(opnd_d) * PROD_W'(let_q ? RECIP_26 : RECIP_10);
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			emit_buf[ptr_q] <= wr_char;
		end
		if (rd_en) begin
			rd_char_q <= emit_buf[ptr_q];
		end
	end

	`SCC_ASSERT_NOW(a_err_shape, clk, arst_n, out_valid_q && out_q.error, (out_q.out_char == 8'h00) && out_q.out_last, "error result not a single zero character")
	`SCC_ASSERT_NEXT(a_bad_to_err, clk, arst_n, (state_q == B_IDLE) && q_valid && q_job.bad, state_q == B_ERR, "bad token not routed to error")

endmodule

### rtl/spreadsheet_cell_notation_converter.sv
// top level of the spreadsheet cell notation converter
//
// Converts a cell reference between R<row>C<col> form and <letters><row> form. The reference
// arrives one character per request with in_last on its final character; the converted text
// leaves one character per request with out_last on its final character, or as one request
// with error set and out_char zero. The front end takes one character per cycle while the
// two-token queue has room. For every digit or letter it produces, the back end does one
// reciprocal multiply and then one remainder and buffer write; it writes each literal R or C
// directly, and then reads each character from the emit buffer and sends it, waiting while
// the output is not free. The back end takes a new token from the queue only when idle; an
// error token goes straight to a single error request.
module spreadsheet_cell_notation_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scc_pkg::in_req_t  in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output scc_pkg::out_req_t out_req
);
	import scc_pkg::*;

	q_ctl_t q_ctl;
	job_t   push_job;
	logic   pop;
	logic   q_valid;
	job_t   q_job;
	logic   full;

	scc_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.full     (full),
		.q_ctl    (q_ctl),
		.push_job (push_job)
	);

	scc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_ctl    (q_ctl),
		.push_job (push_job),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job),
		.full     (full)
	);

	scc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_req   (out_req)
	);

endmodule

### rtl/scc_parse.sv
// front end: parses reference characters and hands finished tokens to the queue
module scc_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  scc_pkg::in_req_t in_req,
	input  logic             full,
	output scc_pkg::q_ctl_t  q_ctl,
	output scc_pkg::job_t    push_job
);
	import scc_pkg::*;

	logic [POS_W-1:0]      pos_q;
	logic                  srd_q, srd_n;
	logic                  seen_q, seen_n;
	logic                  digit_q, digit_n;
	logic                  bad_q, bad_n;
	logic [VALUE_BITS-1:0] letter_q, letter_n;
	logic [VALUE_BITS-1:0] first_q, first_n;
	logic [VALUE_BITS-1:0] second_q, second_n;

	logic                  is_letter;
	logic                  is_digit;
	logic [4:0]            letter_code;
	logic [4:0]            digit_code;
	logic [VALUE_BITS+4:0] acc_wide;
	logic [VALUE_BITS+4:0] acc_base;
	logic [4:0]            acc_radix;
	logic [4:0]            acc_add;
	logic                  acc_ovf;
	logic                  accept;
	logic                  rc_form;

	scc_front u_front (
		.in_char     (in_req.in_char),
		.is_letter   (is_letter),
		.is_digit    (is_digit),
		.letter_code (letter_code),
		.digit_code  (digit_code)
	);

	assign in_ready    = !full;
	assign accept      = in_valid && in_ready;

	// one shared accumulate step: acc * radix + code, with overflow check
	always_comb begin
		if (is_letter) begin
			acc_base  = (VALUE_BITS+5)'(letter_q);
			acc_radix = RADIX_26;
			acc_add   = letter_code;
		end else if (seen_q) begin
			acc_base  = (VALUE_BITS+5)'(second_q);
			acc_radix = RADIX_10;
			acc_add   = digit_code;
		end else begin
			acc_base  = (VALUE_BITS+5)'(first_q);
			acc_radix = RADIX_10;
			acc_add   = digit_code;
		end
		acc_wide = acc_base * (VALUE_BITS+5)'(acc_radix) + (VALUE_BITS+5)'(acc_add);
		acc_ovf  = |acc_wide[VALUE_BITS+4:VALUE_BITS];
	end

	always_comb begin
		srd_n    = srd_q;
		seen_n   = seen_q;
		digit_n  = digit_q;
		bad_n    = bad_q;
		letter_n = letter_q;
		first_n  = first_q;
		second_n = second_q;
		if (is_letter) begin
			if (srd_q && !seen_q && digit_q && (in_req.in_char == CH_C)) begin
				seen_n = 1'b1;
			end else if (digit_q) begin
				bad_n = 1'b1;
			end else if (acc_ovf) begin
				bad_n = 1'b1;
			end else begin
				letter_n = acc_wide[VALUE_BITS-1:0];
			end
		end else if (is_digit) begin
			if (!digit_q && (letter_q == '0)) begin
				bad_n = 1'b1;
			end
			if ((pos_q == POS_W'(1)) && !digit_q && (letter_q == LETTER_R)) begin
				srd_n = 1'b1;
			end
			digit_n = 1'b1;
			if (acc_ovf) begin
				bad_n = 1'b1;
			end else if (seen_q) begin
				second_n = acc_wide[VALUE_BITS-1:0];
			end else begin
				first_n = acc_wide[VALUE_BITS-1:0];
			end
		end else begin
			bad_n = 1'b1;
		end
	end

	assign rc_form        = srd_n && seen_n;
	assign push_job.rc_form = rc_form;
	assign push_job.row   = first_n;
	assign push_job.col   = rc_form ? second_n : letter_n;
	assign push_job.bad   = bad_n || (first_n == '0) || (rc_form && (second_n == '0));
	assign q_ctl.push     = accept && in_req.in_last;
	assign q_ctl.full     = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			srd_q    <= 1'b0;
			seen_q   <= 1'b0;
			digit_q  <= 1'b0;
			bad_q    <= 1'b0;
			letter_q <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (in_req.in_last) begin
				pos_q    <= '0;
				srd_q    <= 1'b0;
				seen_q   <= 1'b0;
				digit_q  <= 1'b0;
				bad_q    <= 1'b0;
				letter_q <= '0;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
				srd_q    <= srd_n;
				seen_q   <= seen_n;
				digit_q  <= digit_n;
				bad_q    <= bad_n;
				letter_q <= letter_n;
				first_q  <= first_n;
				second_q <= second_n;
			end
		end
	end

endmodule
